### hdl/gzip_stored_block_framer_assert.svh
// assertion macros shared by the framer modules
// no dependencies; define ASSERT_OFF to drop every check
`ifndef GZIP_STORED_BLOCK_FRAMER_ASSERT_SVH
`define GZIP_STORED_BLOCK_FRAMER_ASSERT_SVH

`ifndef ASSERT_OFF
`define GZSB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gzsb assertion failed");
`define GZSB_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("gzsb forbidden condition");
`else
`define GZSB_ASSERT(label, clk, rst, prop)
`define GZSB_NEVER(label, clk, rst, expr)
`endif

`endif

### hdl/gzsb_pkg.sv
// shared types, constants and the crc byte step for the gzip stored-block framer
// no dependencies
package gzsb_pkg;

   localparam logic [15:0] BLOCK_LIMIT = 16'd65535;
   localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;
   localparam logic [31:0] LENGTH_RST  = 32'd1;

   // fixed header bytes
   localparam logic [7:0] GZ_ID1      = 8'h1F;
   localparam logic [7:0] GZ_ID2      = 8'h8B;
   localparam logic [7:0] GZ_CM       = 8'h08;
   localparam logic [7:0] GZ_ZERO     = 8'h00;
   localparam logic [7:0] GZ_OS       = 8'hFF;
   localparam logic [7:0] BFINAL_SET  = 8'h01;

   // places in the output sequence of one word
   localparam logic [4:0] POS_ID1       = 5'd0;
   localparam logic [4:0] POS_ID2       = 5'd1;
   localparam logic [4:0] POS_CM        = 5'd2;
   localparam logic [4:0] POS_ZERO_LO   = 5'd3;
   localparam logic [4:0] POS_ZERO_HI   = 5'd8;
   localparam logic [4:0] POS_OS        = 5'd9;
   localparam logic [4:0] POS_BFLAG     = 5'd10;
   localparam logic [4:0] POS_LEN0      = 5'd11;
   localparam logic [4:0] POS_LEN1      = 5'd12;
   localparam logic [4:0] POS_NLEN0     = 5'd13;
   localparam logic [4:0] POS_NLEN1     = 5'd14;
   localparam logic [4:0] POS_DATA      = 5'd15;
   localparam logic [4:0] POS_CRC0      = 5'd16;
   localparam logic [4:0] POS_CRC1      = 5'd17;
   localparam logic [4:0] POS_CRC2      = 5'd18;
   localparam logic [4:0] POS_CRC3      = 5'd19;
   localparam logic [4:0] POS_ISIZE0    = 5'd20;
   localparam logic [4:0] POS_ISIZE1    = 5'd21;
   localparam logic [4:0] POS_ISIZE2    = 5'd22;
   localparam logic [4:0] POS_ISIZE3    = 5'd23;

   // everything needed to emit the bytes caused by one payload word
   typedef struct packed {
      logic        hdr;
      logic        blk;
      logic        trl;
      logic        final_blk;
      logic [15:0] size;
      logic [7:0]  data;
      logic [31:0] crc;
      logic [31:0] isize;
   } job_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

### hdl/gzsb_planner.sv
// stream state (crc, byte count, bytes left in the block) and the per-word job it plans
// depends on gzsb_pkg and gzip_stored_block_framer_assert.svh
`include "gzip_stored_block_framer_assert.svh"

module gzsb_planner (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   output gzsb_pkg::job_type job
);
   import gzsb_pkg::*;

   logic [31:0] payload_length_ff;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] bytes_done_ff, bytes_done_in;
   logic [15:0] block_left_ff, block_left_in;
   logic        header_sent_ff, header_sent_in;

   logic [32:0] diff;
   logic        short_rem;
   logic        big_rem;
   logic        ends;
   logic        need_blk;
   logic [15:0] size;
   logic [31:0] crc_next;
   logic [31:0] done_next;

   always_comb begin
      // remaining = length - done, or one when the length is already used up
      diff      = {1'b0, payload_length_ff} - {1'b0, bytes_done_ff};
      short_rem = diff[32] || (diff[31:0] == 32'd0);
      big_rem   = !short_rem && (diff[31:16] != 16'd0);
      ends      = short_rem || (diff[31:0] == 32'd1);
      size      = short_rem ? 16'd1 : (big_rem ? BLOCK_LIMIT : diff[15:0]);
      need_blk  = (block_left_ff == 16'd0);
      crc_next  = crc_byte(crc_ff, data_byte);
      done_next = bytes_done_ff + 32'd1;

      job.hdr       = !header_sent_ff;
      job.blk       = need_blk;
      job.trl       = ends;
      job.final_blk = !big_rem;
      job.size      = size;
      job.data      = data_byte;
      job.crc       = ~crc_next;
      job.isize     = done_next;

      crc_in         = crc_ff;
      bytes_done_in  = bytes_done_ff;
      block_left_in  = block_left_ff;
      header_sent_in = header_sent_ff;
      if (accept) begin
         if (ends) begin
            crc_in         = CRC_INIT;
            bytes_done_in  = 32'd0;
            block_left_in  = 16'd0;
            header_sent_in = 1'b0;
         end else begin
            crc_in         = crc_next;
            bytes_done_in  = done_next;
            block_left_in  = need_blk ? (size - 16'd1) : (block_left_ff - 16'd1);
            header_sent_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         payload_length_ff <= LENGTH_RST;
         crc_ff            <= CRC_INIT;
         bytes_done_ff     <= 32'd0;
         block_left_ff     <= 16'd0;
         header_sent_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            payload_length_ff <= csr_wr_data;
         end
         crc_ff         <= crc_in;
         bytes_done_ff  <= bytes_done_in;
         block_left_ff  <= block_left_in;
         header_sent_ff <= header_sent_in;
      end
   end

   `GZSB_ASSERT(a_end_clears, clock, reset,
                (accept && job.trl) |=> (bytes_done_ff == 32'd0 && !header_sent_ff))
   `GZSB_ASSERT(a_open_block_has_hdr, clock, reset,
                (block_left_ff != 16'd0) |-> header_sent_ff)
   `GZSB_NEVER(a_idle_state_moves, clock, reset,
               !$past(accept) && !$past(reset) && (bytes_done_ff != $past(bytes_done_ff)))

endmodule

### hdl/gzsb_emitter.sv
// job register, byte sequencer and output register
// depends on gzsb_pkg and gzip_stored_block_framer_assert.svh
`include "gzip_stored_block_framer_assert.svh"

module gzsb_emitter (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  gzsb_pkg::job_type job,
   output logic              can_load,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_run_last,
   output logic              rsp_stream_end
);
   import gzsb_pkg::*;

   job_type     job_ff;
   logic        job_valid_ff, job_valid_in;
   logic [4:0]  pos_ff, pos_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_last_ff;
   logic        rsp_end_ff;

   logic        out_free;
   logic        advance;
   logic        job_last;
   logic [4:0]  pos_next;
   logic [4:0]  pos_start;
   logic [7:0]  cur_byte;

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      advance   = job_valid_ff && out_free;
      job_last  = (pos_ff == POS_ISIZE3) || (pos_ff == POS_DATA && !job_ff.trl);
      can_load  = !job_valid_ff || (advance && job_last);

      pos_start = job.hdr ? POS_ID1 : (job.blk ? POS_BFLAG : POS_DATA);
      // skip the block header when none is due
      pos_next  = (pos_ff == POS_OS && !job_ff.blk) ? POS_DATA : (pos_ff + 5'd1);

      case (pos_ff) inside
         POS_ID1:                 cur_byte = GZ_ID1;
         POS_ID2:                 cur_byte = GZ_ID2;
         POS_CM:                  cur_byte = GZ_CM;
         [POS_ZERO_LO:POS_ZERO_HI]: cur_byte = GZ_ZERO;
         POS_OS:                  cur_byte = GZ_OS;
         POS_BFLAG:               cur_byte = job_ff.final_blk ? BFINAL_SET : GZ_ZERO;
         POS_LEN0:                cur_byte = job_ff.size[7:0];
         POS_LEN1:                cur_byte = job_ff.size[15:8];
         POS_NLEN0:               cur_byte = ~job_ff.size[7:0];
         POS_NLEN1:               cur_byte = ~job_ff.size[15:8];
         POS_DATA:                cur_byte = job_ff.data;
         POS_CRC0:                cur_byte = job_ff.crc[7:0];
         POS_CRC1:                cur_byte = job_ff.crc[15:8];
         POS_CRC2:                cur_byte = job_ff.crc[23:16];
         POS_CRC3:                cur_byte = job_ff.crc[31:24];
         POS_ISIZE0:              cur_byte = job_ff.isize[7:0];
         POS_ISIZE1:              cur_byte = job_ff.isize[15:8];
         POS_ISIZE2:              cur_byte = job_ff.isize[23:16];
         POS_ISIZE3:              cur_byte = job_ff.isize[31:24];
         default:                 cur_byte = GZ_ZERO;
      endcase

      job_valid_in = job_valid_ff;
      pos_in       = pos_ff;
      if (load) begin
         job_valid_in = 1'b1;
         pos_in       = pos_start;
      end else if (advance) begin
         if (job_last) begin
            job_valid_in = 1'b0;
         end else begin
            pos_in = pos_next;
         end
      end

      rsp_valid_in = advance ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= POS_ID1;
      end else begin
         job_valid_ff <= job_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         job_ff <= job;
      end
      if (advance) begin
         rsp_byte_ff <= cur_byte;
         rsp_last_ff <= job_last;
         rsp_end_ff  <= job_last && (pos_ff == POS_ISIZE3);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_run_last   = rsp_last_ff;
   assign rsp_stream_end = rsp_end_ff;

   `GZSB_ASSERT(a_end_is_last, clock, reset,
                (rsp_valid_ff && rsp_end_ff) |-> rsp_last_ff)
   `GZSB_ASSERT(a_load_when_free, clock, reset,
                load |-> (!job_valid_ff || (advance && job_last)))
   `GZSB_NEVER(a_pos_range, clock, reset,
               job_valid_ff && (pos_ff > POS_ISIZE3))

endmodule

### hdl/gzip_stored_block_framer.sv
// top level of the gzip stored-block framer
// depends on gzsb_pkg, gzsb_planner and gzsb_emitter
//
//   channel  handshake              payload
//   req      req_valid / req_stall  req_data_byte
//   rsp      rsp_valid / rsp_stall  rsp_out_byte, rsp_run_last, rsp_stream_end
//   csr      csr_wr_en              csr_wr_data (payload length)
//
// one output word leaves per cycle unless rsp stalls; a payload word causes one data
// byte, plus 10 gzip header, 5 block header and 8 trailer bytes when those are due
// the job register takes a new word in the cycle its previous job emits its last byte
// reset is synchronous and clears the stream state; the length returns to 1
// a stall on rsp holds the output register and the job, and then stalls req
module gzip_stored_block_framer (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_stream_end
);
   import gzsb_pkg::*;

   job_type job;
   logic    can_load;
   logic    accept;

   assign req_stall = !can_load;
   assign accept    = req_valid && can_load;

   gzsb_planner u_planner (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .job         (job)
   );

   gzsb_emitter u_emitter (
      .clock          (clock),
      .reset          (reset),
      .load           (accept),
      .job            (job),
      .can_load       (can_load),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_stream_end (rsp_stream_end)
   );

endmodule

### test/tb_gzip_stored_block_framer.sv
// self-checking bench for gzip_stored_block_framer: a directed table, a receiver
// hold-off and random streams, all checked word by word
// depends only on the framer rtl and its package
module tb_gzip_stored_block_framer;

   localparam logic [31:0] CRC_POLY_LE  = 32'hEDB88320;
   localparam logic [15:0] BLOCK_MAX    = 16'hFFFF;
   localparam logic [7:0]  BFINAL_BYTE  = 8'h01;
   localparam logic [7:0]  BMORE_BYTE   = 8'h00;
   localparam int          QUIET_LIMIT  = 4000;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          TAIL_CYCLES  = 50;
   localparam int          RAND_ITEMS   = 260;
   localparam int          PRESSURE_LEN = 40;

   localparam logic [7:0] GZIP_HEAD [10] = '{8'h1F, 8'h8B, 8'h08, 8'h00, 8'h00,
                                             8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};

   // idling per mode: none, sender, receiver, both lightly
   localparam int SEND_IDLE [4] = '{0, 76, 0, 7};
   localparam int RECV_STALL [4] = '{0, 0, 76, 7};

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       stream_end;
   } gz_word_type;

   typedef struct {
      int         count;
      logic [7:0] first;
      logic [7:0] last;
   } row_check_type;

   typedef enum logic {ROW_LEN, ROW_BYTE} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [31:0]  value;
      logic [4:0]   count;   // words caused by this byte, 0 where left to the predictor
      logic [7:0]   first;
      logic [7:0]   last;
   } dir_row_type;

   localparam int NUM_ROWS = 23;
   localparam dir_row_type DIRECTED [NUM_ROWS] = '{
      '{ROW_BYTE, 32'h00,       5'd24, 8'h1F, 8'h00},  // default length 1, whole stream
      '{ROW_BYTE, 32'hFF,       5'd24, 8'h1F, 8'h00},
      '{ROW_LEN,  32'h0,        5'd0,  8'h00, 8'h00},  // zero length acts as one
      '{ROW_BYTE, 32'hA5,       5'd24, 8'h1F, 8'h00},
      '{ROW_LEN,  32'hFFFFFFFF, 5'd0,  8'h00, 8'h00},  // largest length, non-final block
      '{ROW_BYTE, 32'h00,       5'd16, 8'h1F, 8'h00},
      '{ROW_BYTE, 32'hFF,       5'd1,  8'hFF, 8'hFF},
      '{ROW_BYTE, 32'h5A,       5'd0,  8'h00, 8'h00},
      '{ROW_LEN,  32'h2,        5'd0,  8'h00, 8'h00},  // lowered below bytes done
      '{ROW_BYTE, 32'h3C,       5'd9,  8'h3C, 8'h00},
      '{ROW_LEN,  32'h2,        5'd0,  8'h00, 8'h00},
      '{ROW_BYTE, 32'h01,       5'd16, 8'h1F, 8'h01},
      '{ROW_LEN,  32'h5,        5'd0,  8'h00, 8'h00},  // raised mid-stream
      '{ROW_BYTE, 32'h02,       5'd1,  8'h02, 8'h02},
      '{ROW_BYTE, 32'h03,       5'd6,  8'h01, 8'h03},
      '{ROW_BYTE, 32'h04,       5'd0,  8'h00, 8'h00},
      '{ROW_BYTE, 32'h80,       5'd9,  8'h80, 8'h00},
      '{ROW_LEN,  32'h2,        5'd0,  8'h00, 8'h00},
      '{ROW_BYTE, 32'h20,       5'd16, 8'h1F, 8'h20},
      '{ROW_LEN,  32'h4,        5'd0,  8'h00, 8'h00},
      '{ROW_BYTE, 32'h21,       5'd1,  8'h21, 8'h21},
      '{ROW_LEN,  32'h1,        5'd0,  8'h00, 8'h00},  // lowered with the block used up
      '{ROW_BYTE, 32'h22,       5'd14, 8'h01, 8'h00}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = 32'd0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_last;
   logic        rsp_stream_end;

   // predictor state
   logic [31:0] len_reg    = 32'd1;
   logic [31:0] crc_acc    = 32'hFFFFFFFF;
   logic [31:0] done_count = 32'd0;
   logic [15:0] blk_left   = 16'd0;
   logic        hdr_done   = 1'b0;

   gz_word_type   expected_words [$];
   row_check_type row_checks [$];

   int mismatch_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_req = 0;
   int hold_seen = 0;
   int hold_count = 0;
   int rand_sent = 0;

   gzip_stored_block_framer DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_stream_end (rsp_stream_end)
   );

   always #5 clock = ~clock;

   function automatic gz_word_type plain_word(input logic [7:0] b);
      return '{out_byte: b, run_last: 1'b0, stream_end: 1'b0};
   endfunction

   // works out every word one payload byte causes and queues them
   function automatic void frame_word(input logic [7:0] b, output int n,
                                      output logic [7:0] first, output logic [7:0] last);
      gz_word_type burst [$];
      logic [32:0] eff_len;
      logic [32:0] remaining;
      logic [15:0] size;
      logic [31:0] c;
      eff_len = {1'b0, len_reg};
      if (done_count >= len_reg) eff_len = {1'b0, done_count} + 33'd1;
      if (!hdr_done) begin
         for (int i = 0; i < 10; i++) burst = {burst, plain_word(GZIP_HEAD[i])};
         hdr_done = 1'b1;
      end
      if (blk_left == 16'd0) begin
         remaining = eff_len - {1'b0, done_count};
         size = (remaining < {17'd0, BLOCK_MAX}) ? remaining[15:0] : BLOCK_MAX;
         burst = {burst, plain_word((({1'b0, done_count} + {17'd0, size}) == eff_len) ?
                                    BFINAL_BYTE : BMORE_BYTE)};
         burst = {burst, plain_word(size[7:0])};
         burst = {burst, plain_word(size[15:8])};
         burst = {burst, plain_word(~size[7:0])};
         burst = {burst, plain_word(~size[15:8])};
         blk_left = size;
      end
      burst = {burst, plain_word(b)};
      c = crc_acc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY_LE) : (c >> 1);
      crc_acc = c;
      done_count = done_count + 32'd1;
      if (blk_left != 16'd0) blk_left = blk_left - 16'd1;
      if ({1'b0, done_count} >= eff_len) begin
         c = ~crc_acc;
         for (int k = 0; k < 4; k++) burst = {burst, plain_word(c[8*k +: 8])};
         for (int k = 0; k < 4; k++) burst = {burst, plain_word(done_count[8*k +: 8])};
         burst[burst.size() - 1].stream_end = 1'b1;
         crc_acc = 32'hFFFFFFFF;
         done_count = 32'd0;
         blk_left = 16'd0;
         hdr_done = 1'b0;
      end
      burst[burst.size() - 1].run_last = 1'b1;
      n = burst.size();
      first = burst[0].out_byte;
      last = burst[n-1].out_byte;
      expected_words = {expected_words, burst};
   endfunction

   task automatic log_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch: %s", msg);
   endtask

   always @(posedge clock) begin : monitor
      gz_word_type   want;
      row_check_type row;
      int            n;
      logic [7:0]    f;
      logic [7:0]    l;
      if (!reset) begin
         if (csr_wr_en) len_reg = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               log_mismatch($sformatf("unexpected word byte %02h last %b end %b",
                                      rsp_out_byte, rsp_run_last, rsp_stream_end));
            end else begin
               want = expected_words.pop_front();
               if (rsp_out_byte !== want.out_byte || rsp_run_last !== want.run_last ||
                   rsp_stream_end !== want.stream_end)
                  log_mismatch($sformatf("expected byte %02h last %b end %b, got %02h %b %b",
                                         want.out_byte, want.run_last, want.stream_end,
                                         rsp_out_byte, rsp_run_last, rsp_stream_end));
            end
         end
         if (req_valid && !req_stall) begin
            frame_word(req_data_byte, n, f, l);
            if (row_checks.size() != 0) begin
               row = row_checks.pop_front();
               if (row.count != 0 && (row.count != n || row.first !== f || row.last !== l))
                  log_mismatch($sformatf(
                     "row for %02h: wanted %0d words %02h..%02h, got %0d %02h..%02h",
                     req_data_byte, row.count, row.first, row.last, n, f, l));
            end
         end
      end
   end

   // receiver: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_count = HOLD_CYCLES;
      end
      if (hold_count != 0) begin
         hold_count--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic set_mode(input int m);
      send_idle_pct = SEND_IDLE[m];
      stall_pct = RECV_STALL[m];
   endtask

   task automatic put_byte(input logic [7:0] b, input int count,
                           input logic [7:0] first, input logic [7:0] last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      row_checks = {row_checks, row_check_type'{count, first, last}};
      req_valid <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_run(input int n);
      for (int i = 0; i < n; i++) begin
         put_byte(8'($urandom_range(0, 255)), 0, 8'h00, 8'h00);
         rand_sent++;
      end
   endtask

   // sender pauses until every expected word has come out
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic set_length(input logic [31:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int          stream_idx;
      int          r;
      int          part;
      logic [31:0] new_len;
      stream_idx = 0;
      set_mode(3);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_ROWS; i++) begin
         if (DIRECTED[i].kind == ROW_LEN) begin
            drain();
            set_length(DIRECTED[i].value);
         end else begin
            put_byte(DIRECTED[i].value[7:0], int'(DIRECTED[i].count),
                     DIRECTED[i].first, DIRECTED[i].last);
         end
      end

      // receiver holds off while the sender keeps offering, so the input backs up
      drain();
      set_mode(0);
      set_length(PRESSURE_LEN);
      hold_req++;
      send_run(PRESSURE_LEN);
      drain();

      rand_sent = 0;
      while (rand_sent < RAND_ITEMS) begin
         set_mode((stream_idx / 5) % 4);
         stream_idx++;
         if (len_reg <= 12 && $urandom_range(99) < 25) begin
            new_len = len_reg;   // next stream straight after the trailer
         end else begin
            r = $urandom_range(99);
            if (r < 8) new_len = 32'd0;
            else if (r < 12) new_len = 32'hFFFFFFFF;
            else if (r < 16) new_len = $urandom | 32'h0001_0000;
            else new_len = $urandom_range(1, 12);
            drain();
            set_length(new_len);
         end
         if (new_len > 12 || (new_len > 1 && $urandom_range(99) < 20)) begin
            // change the length part way through the stream
            part = (new_len > 12) ? $urandom_range(1, 6) : $urandom_range(1, new_len - 1);
            send_run(part);
            drain();
            new_len = $urandom_range(0, 12);
            set_length(new_len);
            send_run((done_count >= new_len) ? 1 : new_len - done_count);
         end else begin
            send_run((new_len == 0) ? 1 : new_len);
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_words.size() != 0)
         log_mismatch($sformatf("%0d expected words never came", expected_words.size()));
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
